// ===== rtl/b32_pkg.sv =====
// ----------------------------------------------------------------------------
// b32_pkg
// Shared types, codes and the symbol table for the Base32 stream codec.
// ----------------------------------------------------------------------------
package b32_pkg;

  // Mode register values
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_HIGH    = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  // ASCII landmarks used by the decoder
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // Default depth of the job queue between front and back
  localparam int B32_QDEPTH = 2;

  // One job: up to three result words from one accepted input word
  typedef struct packed {
    logic [1:0]      num;     // number of results, 1..3
    logic [1:0]      status;  // status shared by all results of the job
    logic [2:0][7:0] val;     // result values, slot 0 goes out first
  } b32_job_t;

  // Symbol table: 0..25 -> 'A'..'Z', 26..31 -> '2'..'7'
  function automatic logic [7:0] b32_sym(input logic [4:0] idx);
    logic [7:0] ch;
    if (idx < 5'd26) begin
      ch = CH_UP_A + {3'd0, idx};
    end else begin
      ch = CH_TWO + {3'd0, idx - 5'd26};
    end
    return ch;
  endfunction

endpackage

// ===== rtl/b32_stream_ifs.sv =====
// ----------------------------------------------------------------------------
// b32_stream_ifs
// Valid/ready stream interfaces for the input and result channels.
// ----------------------------------------------------------------------------
interface b32_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_value;
  logic       in_last;

  modport source (output valid, in_value, in_last, input ready);
  modport sink   (input valid, in_value, in_last, output ready);
endinterface

interface b32_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_value;
  logic [1:0] status;
  logic       run_last;

  modport source (output valid, out_value, status, run_last, input ready);
  modport sink   (input valid, out_value, status, run_last, output ready);
endinterface

// ===== rtl/b32_front.sv =====
// ----------------------------------------------------------------------------
// b32_front
// Accepts input words, holds mode and the bit accumulator, and turns each
// word into a job of zero to three results for the back end.
// ----------------------------------------------------------------------------
module b32_front
  import b32_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  b32_in_if.sink   in_ch,
  input  logic     q_full,
  output logic     push,
  output b32_job_t push_job
);

  logic        mode_r;
  logic [11:0] buf_r, buf_nxt;
  logic [2:0]  cnt_r, cnt_nxt;

  logic accept;

  // encode path
  logic [11:0] e_buf;
  logic [3:0]  e_cnt;
  logic [2:0]  c1, c2, psh;
  logic [4:0]  idx1, idx2, pidx;
  logic [6:0]  b1, b2;
  logic        has2, pad;

  // decode path
  logic        too_high, is_sym, is_skip;
  logic [4:0]  q;
  logic [11:0] d_buf;
  logic [3:0]  d_cnt;
  logic        has_byte;
  logic [2:0]  dc;
  logic [7:0]  dbyte;
  logic [6:0]  db;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // encode: shift in a byte, peel off one or two 5-bit groups, pad on last
  always_comb begin
    e_buf = {buf_r[3:0], in_ch.in_value};
    e_cnt = {1'b0, cnt_r} + 4'd8;
    c1    = 3'(e_cnt - 4'd5);
    idx1  = 5'(e_buf >> c1);
    b1    = 7'(e_buf & ((12'd1 << c1) - 12'd1));
    has2  = (c1 >= 3'd5);
    idx2  = 5'(b1 >> (c1 - 3'd5));
    c2    = has2 ? (c1 - 3'd5) : c1;
    b2    = has2 ? (b1 & ((7'd1 << c2) - 7'd1)) : b1;
    pad   = in_ch.in_last && (c2 != 3'd0) && (c2 < 3'd5);
    psh   = 3'd5 - c2;
    pidx  = 5'(b2 << psh);
  end

  // decode: classify the character, shift in 5 bits, emit a full byte
  always_comb begin
    too_high = (in_ch.in_value > CH_LO_Z);
    is_sym   = 1'b1;
    q        = 5'd0;
    if (in_ch.in_value >= CH_UP_A && in_ch.in_value <= CH_UP_Z) begin
      q = 5'(in_ch.in_value - CH_UP_A);
    end else if (in_ch.in_value >= CH_LO_A && in_ch.in_value <= CH_LO_Z) begin
      q = 5'(in_ch.in_value - CH_LO_A);
    end else if (in_ch.in_value >= CH_TWO && in_ch.in_value <= CH_SEVEN) begin
      q = 5'(in_ch.in_value - CH_TWO + 8'd26);
    end else begin
      is_sym = 1'b0;
    end
    is_skip  = (in_ch.in_value == CH_DASH) || (in_ch.in_value == CH_EQ);
    d_buf    = {buf_r[6:0], q};
    d_cnt    = {1'b0, cnt_r} + 4'd5;
    has_byte = (d_cnt >= 4'd8);
    dbyte    = 8'(d_buf >> (d_cnt - 4'd8));
    dc       = has_byte ? 3'(d_cnt - 4'd8) : d_cnt[2:0];
    db       = has_byte ? 7'(d_buf & ((12'd1 << dc) - 12'd1)) : d_buf[6:0];
  end

  // job build and accumulator next state
  always_comb begin
    buf_nxt         = buf_r;
    cnt_nxt         = cnt_r;
    push_job.num    = 2'd0;
    push_job.status = ST_OK;
    push_job.val    = '0;
    if (mode_r == MODE_ENC) begin
      push_job.val[0] = b32_sym(idx1);
      if (has2) begin
        push_job.val[1] = b32_sym(idx2);
        push_job.val[2] = b32_sym(pidx);
      end else begin
        push_job.val[1] = b32_sym(pidx);
      end
      push_job.num = 2'd1 + {1'b0, has2} + {1'b0, pad};
      buf_nxt      = {5'd0, b2};
      cnt_nxt      = c2;
    end else if (too_high) begin
      push_job.num    = 2'd1;
      push_job.status = ST_HIGH;
    end else if (is_sym) begin
      push_job.val[0] = dbyte;
      push_job.num    = {1'b0, has_byte};
      buf_nxt         = {5'd0, db};
      cnt_nxt         = dc;
    end else if (!is_skip) begin
      push_job.num    = 2'd1;
      push_job.status = ST_ILLEGAL;
    end
    if (in_ch.in_last) begin
      buf_nxt = '0;
      cnt_nxt = '0;
    end
  end

  assign push = accept && (push_job.num != 2'd0);

  // mode and accumulator; a mode write clears the accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENC;
      buf_r  <= '0;
      cnt_r  <= '0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
      buf_r  <= '0;
      cnt_r  <= '0;
    end else if (accept) begin
      buf_r <= buf_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/b32_queue.sv =====
// ----------------------------------------------------------------------------
// b32_queue
// Small job FIFO that decouples the front end from the result serializer.
// ----------------------------------------------------------------------------
module b32_queue
  import b32_pkg::*;
#(
  parameter int DEPTH = B32_QDEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  b32_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     q_valid,
  output b32_job_t q_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b32_job_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_job   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/b32_back.sv =====
// ----------------------------------------------------------------------------
// b32_back
// Takes jobs from the queue and sends their results one word per cycle while
// out_ch is ready, flagging run_last on the final word of each job.
// ----------------------------------------------------------------------------
module b32_back
  import b32_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  b32_job_t  q_job,
  output logic      pop,
  b32_out_if.source out_ch
);

  b32_job_t   job_r;
  logic [1:0] idx_r;
  logic       busy_r;
  logic       is_last;
  logic       done;

  assign is_last = (idx_r == (job_r.num - 2'd1));
  assign done    = busy_r && out_ch.ready && is_last;
  assign pop     = q_valid && (!busy_r || done);

  // output words come straight from the held job
  assign out_ch.valid     = busy_r;
  assign out_ch.out_value = job_r.val[idx_r];
  assign out_ch.status    = job_r.status;
  assign out_ch.run_last  = is_last;

  // job payload
  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_job;
    end
  end

  // slot index and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r && out_ch.ready) begin
      if (is_last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule

// ===== rtl/base32_stream_codec.sv =====
// ----------------------------------------------------------------------------
// base32_stream_codec
// Base32 encoder/decoder on a bit accumulator, front end and result
// serializer joined by a job queue.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+-------------------------------------
//  in_ch    | in  | valid/ready   | in_value[7:0], in_last
//  out_ch   | out | valid/ready   | out_value[7:0], status[1:0], run_last
//  cfg      | in  | cfg_we        | cfg_wdata (mode: 0 encode, 1 decode)
//
//  An input word becomes a job of zero to three results in its accept cycle;
//  the job is registered in the queue, then in the serializer, before it is driven.
//  One result leaves per cycle while out_ch is ready; encode averages 1.6
//  results per input word, decode at most 1.
//  Input stalls only when the job queue is full; output stalls hold the word.
//  rst_n is synchronous: mode returns to encode, accumulator and queue clear.
// ----------------------------------------------------------------------------
module base32_stream_codec
  import b32_pkg::*;
#(
  parameter int QUEUE_DEPTH = B32_QDEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  b32_in_if.sink    in_ch,
  b32_out_if.source out_ch
);

  logic     q_full, push, pop, q_valid;
  b32_job_t push_job, q_job;

  // classify and build jobs
  b32_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  // job queue
  b32_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  // result serializer
  b32_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (q_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
